// ===== sv/tpcls_pkg.sv =====
`timescale 1ns / 1ps

package tpcls_pkg;

    localparam int MAX_LEVEL  = 16;
    localparam int NUM_CURVES = 16;
    localparam int LANE_W     = $clog2(NUM_CURVES);

    localparam int CAD_W    = 8;
    localparam int LEVEL_W  = 5;
    localparam int WATT_W   = 12;
    localparam int GAIN_W   = 10;
    localparam int OFF_W    = 11;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 1;
    localparam int X2_W     = 2 * CAD_W;
    localparam int FRAC_W   = 20;

    localparam int K0_W  = 27;
    localparam int K1_W  = 22;
    localparam int K2_W  = 16;
    localparam int P1_W  = K1_W + CAD_W;
    localparam int P2_W  = K2_W + X2_W;
    localparam int SUM_W = P2_W + 3;
    localparam int PROD_W = WATT_W + GAIN_W;
    localparam int DIFF_W = PROD_W + 3;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_POWER_GAIN   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_OFFSET = 1'd1;

    localparam logic                CMD_ESTIMATE = 1'b0;
    localparam logic                CMD_SEARCH   = 1'b1;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 10'd256;
    localparam logic [WATT_W-1:0]   WATT_MAX     = {WATT_W{1'b1}};

    // Round to nearest, half away from zero, at 2^20 scale.
    function automatic longint fxp_tenths(longint n);
        if (n >= 0) begin
            return (n * 2097152 + 10) / 20;
        end
        return -((-n * 2097152 + 10) / 20);
    endfunction

    function automatic longint fxp_milli(longint n);
        if (n >= 0) begin
            return (n * 2097152 + 1000) / 2000;
        end
        return -((-n * 2097152 + 1000) / 2000);
    endfunction

    function automatic longint fxp_e5(longint n);
        if (n >= 0) begin
            return (n * 2097152 + 100000) / 200000;
        end
        return -((-n * 2097152 + 100000) / 200000);
    endfunction

    // Lane j holds the curve of level j+1.
    localparam logic signed [K0_W-1:0] K0 [0:NUM_CURVES-1] = '{
        K0_W'(fxp_tenths(-135)), K0_W'(fxp_tenths(-177)), K0_W'(fxp_tenths(-175)),
        K0_W'(fxp_tenths(-209)), K0_W'(fxp_tenths(-279)), K0_W'(fxp_tenths(-267)),
        K0_W'(fxp_tenths(-335)), K0_W'(fxp_tenths(-365)), K0_W'(fxp_tenths(-380)),
        K0_W'(fxp_tenths(-412)), K0_W'(fxp_tenths(-434)), K0_W'(fxp_tenths(-468)),
        K0_W'(fxp_tenths(-490)), K0_W'(fxp_tenths(-534)), K0_W'(fxp_tenths(-499)),
        K0_W'(fxp_tenths(-471))
    };

    localparam logic [K1_W-1:0] K1 [0:NUM_CURVES-1] = '{
        K1_W'(fxp_milli(999)),  K1_W'(fxp_milli(1200)), K1_W'(fxp_milli(1240)),
        K1_W'(fxp_milli(1430)), K1_W'(fxp_milli(1750)), K1_W'(fxp_milli(1900)),
        K1_W'(fxp_milli(2230)), K1_W'(fxp_milli(2500)), K1_W'(fxp_milli(2620)),
        K1_W'(fxp_milli(2850)), K1_W'(fxp_milli(3010)), K1_W'(fxp_milli(3230)),
        K1_W'(fxp_milli(3390)), K1_W'(fxp_milli(3550)), K1_W'(fxp_milli(3370)),
        K1_W'(fxp_milli(3250))
    };

    localparam logic [K2_W-1:0] K2 [0:NUM_CURVES-1] = '{
        K2_W'(fxp_e5(993)),  K2_W'(fxp_e5(1160)), K2_W'(fxp_e5(1400)),
        K2_W'(fxp_e5(1600)), K2_W'(fxp_e5(1720)), K2_W'(fxp_e5(2010)),
        K2_W'(fxp_e5(2250)), K2_W'(fxp_e5(2620)), K2_W'(fxp_e5(3050)),
        K2_W'(fxp_e5(3270)), K2_W'(fxp_e5(3590)), K2_W'(fxp_e5(3640)),
        K2_W'(fxp_e5(3710)), K2_W'(fxp_e5(3830)), K2_W'(fxp_e5(4290)),
        K2_W'(fxp_e5(4640))
    };

    typedef struct packed {
        logic               cmd;
        logic [CAD_W-1:0]   cad;
        logic [LEVEL_W-1:0] lvl;
        logic [WATT_W-1:0]  target;
    } item_t;

    typedef logic [WATT_W-1:0] watt_t;
    typedef watt_t [NUM_CURVES-1:0] watt_vec_t;

endpackage

// ===== sv/trainer_power_curve_level_search.sv =====
`timescale 1ns / 1ps

// Trainer power curve and level search. Command 0 returns the curve watts of
// the given level at the given cadence; command 1 returns the first level
// whose gain- and offset-adjusted curve brackets the target power, with the
// curve watts at that level. Every level curve is evaluated in parallel in a
// five-stage pipeline (cadence square, per-curve products, sum and clamp,
// gain/offset compare, level select), so one transfer is taken every cycle
// unless the output stalls; a stall at the output holds the whole pipeline.
// Configuration writes take effect at once.
module trainer_power_curve_level_search (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // cadence[7:0], level[12:8], target_power[24:13]
    input  logic [tpcls_pkg::S_TDATA_W-1:0]   s_tdata,
    // command[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // chosen_level[4:0], curve_power[16:5]
    output logic [tpcls_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                              cfg_we,
    input  logic [tpcls_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [tpcls_pkg::CFG_W-1:0]       cfg_wdata
);

    localparam int NC = tpcls_pkg::NUM_CURVES;
    localparam int ML = tpcls_pkg::MAX_LEVEL;

    logic                              adv;
    tpcls_pkg::item_t                  in_item;
    logic                              c_valid;
    tpcls_pkg::item_t                  c_item;
    tpcls_pkg::watt_vec_t              c_watts;

    logic [tpcls_pkg::GAIN_W-1:0]      gain_reg;
    logic signed [tpcls_pkg::OFF_W-1:0] offset_reg;

    logic                              s4_valid_reg;
    tpcls_pkg::item_t                  s4_item_reg;
    tpcls_pkg::watt_vec_t              s4_watts_reg;
    logic [NC-1:0]                     s4_le_reg, s4_le_next;
    logic [NC-1:0]                     s4_ge_reg, s4_ge_next;

    logic                              m_tvalid_reg;
    logic [tpcls_pkg::M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    assign in_item.cmd    = s_tuser;
    assign in_item.cad    = s_tdata[7:0];
    assign in_item.lvl    = s_tdata[12:8];
    assign in_item.target = s_tdata[24:13];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= tpcls_pkg::GAIN_RESET;
            offset_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                tpcls_pkg::REG_POWER_GAIN:   gain_reg   <= cfg_wdata[tpcls_pkg::GAIN_W-1:0];
                tpcls_pkg::REG_POWER_OFFSET: offset_reg <= $signed(cfg_wdata[tpcls_pkg::OFF_W-1:0]);
                default: ;
            endcase
        end
    end

    tpcls_curve u_curve (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .in_item   (in_item),
        .out_valid (c_valid),
        .out_item  (c_item),
        .out_watts (c_watts)
    );

    // compare W*gain + 256*offset against 256*target for every level
    always_comb begin
        logic [tpcls_pkg::PROD_W-1:0]       prod;
        logic signed [tpcls_pkg::DIFF_W-1:0] diff;
        logic signed [tpcls_pkg::DIFF_W-1:0] bias;
        bias = (tpcls_pkg::DIFF_W'(offset_reg) <<< 8)
             - $signed({5'b00000, c_item.target, 8'h00});
        s4_le_next = '0;
        s4_ge_next = '0;
        for (int j = 0; j < NC; j++) begin
            prod = tpcls_pkg::PROD_W'(c_watts[j]) * tpcls_pkg::PROD_W'(gain_reg);
            diff = $signed(tpcls_pkg::DIFF_W'(prod)) + bias;
            s4_le_next[j] = (diff <= 0);
            s4_ge_next[j] = (diff >= 0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (adv) begin
            s4_valid_reg <= c_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_item_reg  <= c_item;
            s4_watts_reg <= c_watts;
            s4_le_reg    <= s4_le_next;
            s4_ge_reg    <= s4_ge_next;
        end
    end

    // pick the level, then its curve watts
    always_comb begin
        logic [tpcls_pkg::LANE_W-1:0]  lane;
        logic [tpcls_pkg::LEVEL_W-1:0] chosen;
        if (!s4_le_reg[0]) begin
            lane = '0;
        end else begin
            lane = tpcls_pkg::LANE_W'(ML - 1);
        end
        for (int j = ML - 2; j >= 0; j--) begin
            if (s4_le_reg[j] && s4_ge_reg[j+1]) begin
                lane = tpcls_pkg::LANE_W'(j);
            end
        end
        chosen = tpcls_pkg::LEVEL_W'(lane) + tpcls_pkg::LEVEL_W'(1);
        if (s4_item_reg.cmd == tpcls_pkg::CMD_ESTIMATE) begin
            chosen = s4_item_reg.lvl;
            if (s4_item_reg.lvl == '0) begin
                lane = '0;
            end else if (s4_item_reg.lvl > tpcls_pkg::LEVEL_W'(NC)) begin
                lane = tpcls_pkg::LANE_W'(NC - 1);
            end else begin
                lane = tpcls_pkg::LANE_W'(s4_item_reg.lvl - tpcls_pkg::LEVEL_W'(1));
            end
        end
        m_tdata_next = {7'b0, s4_watts_reg[lane], chosen};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && s4_valid_reg) |=> m_tvalid)
        else $error("search stage result not moved to output");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && s4_valid_reg && s4_item_reg.cmd == tpcls_pkg::CMD_SEARCH)
        |=> (m_tdata[4:0] >= 5'd1 && m_tdata[4:0] <= tpcls_pkg::LEVEL_W'(ML)))
        else $error("searched level out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> ($stable(s4_valid_reg) && $stable(s4_le_reg) && $stable(s4_ge_reg)))
        else $error("pipeline moved during output stall");
`endif

endmodule

// ===== sv/tpcls_curve.sv =====
`timescale 1ns / 1ps

module tpcls_curve (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  logic                 in_valid,
    input  tpcls_pkg::item_t     in_item,
    output logic                 out_valid,
    output tpcls_pkg::item_t     out_item,
    output tpcls_pkg::watt_vec_t out_watts
);

    localparam int NC = tpcls_pkg::NUM_CURVES;

    logic                               s1_valid_reg, s2_valid_reg, s3_valid_reg;
    tpcls_pkg::item_t                   s1_item_reg, s2_item_reg, s3_item_reg;
    logic [tpcls_pkg::X2_W-1:0]         s1_x2_reg;
    logic [tpcls_pkg::P1_W-1:0]         s2_p1_reg [0:NC-1];
    logic [tpcls_pkg::P2_W-1:0]         s2_p2_reg [0:NC-1];
    tpcls_pkg::watt_vec_t               s3_watts_reg, s3_watts_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // square the cadence
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_item_reg <= in_item;
            s1_x2_reg   <= tpcls_pkg::X2_W'(in_item.cad) * tpcls_pkg::X2_W'(in_item.cad);
        end
    end

    // linear and square terms of every curve
    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_item_reg <= s1_item_reg;
            for (int j = 0; j < NC; j++) begin
                s2_p1_reg[j] <= tpcls_pkg::P1_W'(tpcls_pkg::K1[j])
                              * tpcls_pkg::P1_W'(s1_item_reg.cad);
                s2_p2_reg[j] <= tpcls_pkg::P2_W'(tpcls_pkg::K2[j])
                              * tpcls_pkg::P2_W'(s1_x2_reg);
            end
        end
    end

    // sum, truncate to watts, clamp and saturate
    always_comb begin
        logic signed [tpcls_pkg::SUM_W-1:0] sum;
        s3_watts_next = '0;
        for (int j = 0; j < NC; j++) begin
            sum = tpcls_pkg::SUM_W'(tpcls_pkg::K0[j])
                + $signed(tpcls_pkg::SUM_W'(s2_p1_reg[j]))
                + $signed(tpcls_pkg::SUM_W'(s2_p2_reg[j]));
            if (s2_item_reg.cad == '0 || sum < 0) begin
                s3_watts_next[j] = '0;
            end else if (sum[tpcls_pkg::SUM_W-2:tpcls_pkg::FRAC_W+tpcls_pkg::WATT_W] != '0)
            begin
                s3_watts_next[j] = tpcls_pkg::WATT_MAX;
            end else begin
                s3_watts_next[j] =
                    sum[tpcls_pkg::FRAC_W+tpcls_pkg::WATT_W-1:tpcls_pkg::FRAC_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_item_reg  <= s2_item_reg;
            s3_watts_reg <= s3_watts_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_item  = s3_item_reg;
    assign out_watts = s3_watts_reg;

endmodule
